@@ hw/rtl/oar_pkg.sv @@
`timescale 1ns / 1ps

package oar_pkg;

  localparam int MEM_WORDS = 32768;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 16;
  localparam int REG_AW    = 3;
  localparam int SPEC_W    = 12;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam logic [REG_AW-1:0] REG_PC    = 3'd7;
  localparam logic [WORD_W-1:0] WORD_STEP = 16'd2;

  typedef enum logic [1:0] {
    CMD_WR_MEM  = 2'd0,
    CMD_WR_REG  = 2'd1,
    CMD_RESOLVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_REG        = 3'd0,
    MODE_REG_DEF    = 3'd1,
    MODE_AUTOINC    = 3'd2,
    MODE_AUTOINC_DEF = 3'd3,
    MODE_AUTODEC    = 3'd4,
    MODE_AUTODEC_DEF = 3'd5,
    MODE_INDEX      = 3'd6,
    MODE_INDEX_DEF  = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ASRC_REG  = 3'd0,
    ASRC_INC  = 3'd1,
    ASRC_DEC  = 3'd2,
    ASRC_MEMQ = 3'd3,
    ASRC_IDX  = 3'd4,
    ASRC_NUM  = 3'd5
  } asrc_t;

  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_INC  = 2'd1,
    UPD_DEC  = 2'd2
  } upd_t;

  typedef struct packed {
    logic              wr_mem;
    logic              wr_reg;
    logic [REG_AW-1:0] reg_sel;
    upd_t              upd;
    asrc_t             asrc;
    logic              ea_load;
    logic              mem_rd;
    logic              val_from_reg;
    logic              val_from_mem;
    logic              out_load;
    logic              out_slot;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/operand_address_resolver_core.sv @@
`timescale 1ns / 1ps
// A write request completes in S_IDLE; a resolve request steps each operand through S_SPEC,
// then S_IDXQ, S_PTRQ and S_VALQ as its mode needs, and S_OUT (register mode skips all three,
// double-indirect index mode passes all). One request at a time; S_OUT waits for a free
// output. The single memory read port and each mode's dependent reads set the steps.
// Reset: rst_n synchronous, active low; clears the register file and control state,
// word memory holds whatever was last written.
module operand_address_resolver_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] data_word, [31:16] target, [32] has_source, [33] has_dest, [39:34] zero
  input  logic [oar_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] effective_address, [31:16] operand_value
  output logic [oar_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] operand_slot, [1] in_register
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast
);

  oar_pkg::dp_cmd_t           cmd;
  oar_pkg::dp_stat_t          stat;
  logic [oar_pkg::WORD_W-1:0] out_ea;
  logic [oar_pkg::WORD_W-1:0] out_value;
  logic                       out_slot;
  logic                       out_inreg;

  oar_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_cmd        (in_tuser),
    .in_spec       (in_tdata[oar_pkg::SPEC_W-1:0]),
    .in_has_source (in_tdata[32]),
    .in_has_dest   (in_tdata[33]),
    .cmd           (cmd),
    .stat          (stat)
  );

  oar_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .wr_data   (in_tdata[15:0]),
    .wr_target (in_tdata[31:16]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ea    (out_ea),
    .out_value (out_value),
    .out_slot  (out_slot),
    .out_inreg (out_inreg),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_value, out_ea};
  assign out_tuser = {out_inreg, out_slot};

endmodule

@@ hw/rtl/oar_dpath.sv @@
`timescale 1ns / 1ps

module oar_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  oar_pkg::dp_cmd_t             cmd,
  output oar_pkg::dp_stat_t            stat,
  input  logic [oar_pkg::WORD_W-1:0]   wr_data,
  input  logic [oar_pkg::WORD_W-1:0]   wr_target,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [oar_pkg::WORD_W-1:0]   out_ea,
  output logic [oar_pkg::WORD_W-1:0]   out_value,
  output logic                         out_slot,
  output logic                         out_inreg,
  output logic                         out_last
);

  logic [oar_pkg::WORD_W-1:0] rf_r [8];
  logic [oar_pkg::WORD_W-1:0] mem [oar_pkg::MEM_WORDS];
  logic [oar_pkg::WORD_W-1:0] mem_q_r;
  logic [oar_pkg::WORD_W-1:0] ea_r;
  logic [oar_pkg::WORD_W-1:0] val_r;
  logic                       inreg_r;
  logic                       out_valid_r;
  logic [oar_pkg::WORD_W-1:0] out_ea_r;
  logic [oar_pkg::WORD_W-1:0] out_value_r;
  logic                       out_slot_r;
  logic                       out_inreg_r;
  logic                       out_last_r;

  logic [oar_pkg::WORD_W-1:0] rd;
  logic [oar_pkg::WORD_W-1:0] rd_inc;
  logic [oar_pkg::WORD_W-1:0] rd_dec;
  logic [oar_pkg::WORD_W-1:0] idx_base;
  logic [oar_pkg::WORD_W-1:0] addr_calc;

  assign rd       = rf_r[cmd.reg_sel];
  assign rd_inc   = rd + oar_pkg::WORD_STEP;
  assign rd_dec   = rd - oar_pkg::WORD_STEP;
  assign idx_base = (cmd.reg_sel == oar_pkg::REG_PC) ? rd_inc : rd;

  always_comb begin
    case (cmd.asrc)
      oar_pkg::ASRC_REG:  addr_calc = rd;
      oar_pkg::ASRC_INC:  addr_calc = rd_inc;
      oar_pkg::ASRC_DEC:  addr_calc = rd_dec;
      oar_pkg::ASRC_MEMQ: addr_calc = mem_q_r;
      oar_pkg::ASRC_IDX:  addr_calc = idx_base + mem_q_r;
      oar_pkg::ASRC_NUM:  addr_calc = oar_pkg::WORD_W'(cmd.reg_sel);
      default:            addr_calc = rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= '0;
      end
    end else if (cmd.wr_reg) begin
      rf_r[wr_target[oar_pkg::REG_AW-1:0]] <= wr_data;
    end else begin
      case (cmd.upd)
        oar_pkg::UPD_INC: rf_r[cmd.reg_sel] <= rd_inc;
        oar_pkg::UPD_DEC: rf_r[cmd.reg_sel] <= rd_dec;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_mem) begin
      mem[wr_target[oar_pkg::MEM_AW:1]] <= wr_data;
    end
    if (cmd.mem_rd) begin
      mem_q_r <= mem[addr_calc[oar_pkg::MEM_AW:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ea_load) begin
      ea_r <= addr_calc;
    end
    if (cmd.val_from_reg) begin
      val_r   <= rd;
      inreg_r <= 1'b1;
    end else if (cmd.val_from_mem) begin
      val_r   <= mem_q_r;
      inreg_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ea_r    <= ea_r;
      out_value_r <= val_r;
      out_slot_r  <= cmd.out_slot;
      out_inreg_r <= inreg_r;
      out_last_r  <= cmd.out_last;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_ea        = out_ea_r;
  assign out_value     = out_value_r;
  assign out_slot      = out_slot_r;
  assign out_inreg     = out_inreg_r;
  assign out_last      = out_last_r;

endmodule

@@ hw/rtl/oar_ctrl.sv @@
`timescale 1ns / 1ps

module oar_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [oar_pkg::SPEC_W-1:0]  in_spec,
  input  logic                        in_has_source,
  input  logic                        in_has_dest,
  output oar_pkg::dp_cmd_t            cmd,
  input  oar_pkg::dp_stat_t           stat
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SPEC = 6'b000010,
    S_IDXQ = 6'b000100,
    S_PTRQ = 6'b001000,
    S_VALQ = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                     state_r;
  state_t                     state_nxt;
  logic [oar_pkg::SPEC_W-1:0] spec_r;
  logic                       slot_r;
  logic                       slot_nxt;
  logic                       has_dst_r;

  logic [5:0]                 cur_spec;
  oar_pkg::mode_t             mode;
  logic [oar_pkg::REG_AW-1:0] rnum;
  logic                       accept;

  assign cur_spec = slot_r ? spec_r[5:0] : spec_r[11:6];
  assign mode     = oar_pkg::mode_t'(cur_spec[5:3]);
  assign rnum     = cur_spec[2:0];
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt        = state_r;
    slot_nxt         = slot_r;
    cmd.wr_mem       = 1'b0;
    cmd.wr_reg       = 1'b0;
    cmd.reg_sel      = rnum;
    cmd.upd          = oar_pkg::UPD_NONE;
    cmd.asrc         = oar_pkg::ASRC_REG;
    cmd.ea_load      = 1'b0;
    cmd.mem_rd       = 1'b0;
    cmd.val_from_reg = 1'b0;
    cmd.val_from_mem = 1'b0;
    cmd.out_load     = 1'b0;
    cmd.out_slot     = slot_r;
    cmd.out_last     = slot_r || !has_dst_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            oar_pkg::CMD_WR_MEM: cmd.wr_mem = 1'b1;
            oar_pkg::CMD_WR_REG: cmd.wr_reg = 1'b1;
            oar_pkg::CMD_RESOLVE: begin
              slot_nxt = !in_has_source;
              if (in_has_source || in_has_dest) begin
                state_nxt = S_SPEC;
              end
            end
            default: ;
          endcase
        end
      end
      S_SPEC: begin
        cmd.ea_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        case (mode)
          oar_pkg::MODE_REG: begin
            cmd.asrc         = oar_pkg::ASRC_NUM;
            cmd.mem_rd       = 1'b0;
            cmd.val_from_reg = 1'b1;
            state_nxt        = S_OUT;
          end
          oar_pkg::MODE_REG_DEF: begin
            state_nxt = S_VALQ;
          end
          oar_pkg::MODE_AUTOINC, oar_pkg::MODE_AUTOINC_DEF: begin
            cmd.upd   = oar_pkg::UPD_INC;
            cmd.asrc  = (rnum == oar_pkg::REG_PC) ? oar_pkg::ASRC_INC : oar_pkg::ASRC_REG;
            state_nxt = (mode == oar_pkg::MODE_AUTOINC) ? S_VALQ : S_PTRQ;
          end
          oar_pkg::MODE_AUTODEC, oar_pkg::MODE_AUTODEC_DEF: begin
            cmd.upd   = oar_pkg::UPD_DEC;
            cmd.asrc  = oar_pkg::ASRC_DEC;
            state_nxt = (mode == oar_pkg::MODE_AUTODEC) ? S_VALQ : S_PTRQ;
          end
          default: begin
            cmd.reg_sel = oar_pkg::REG_PC;
            cmd.upd     = oar_pkg::UPD_INC;
            cmd.asrc    = oar_pkg::ASRC_INC;
            state_nxt   = S_IDXQ;
          end
        endcase
      end
      S_IDXQ: begin
        cmd.asrc    = oar_pkg::ASRC_IDX;
        cmd.ea_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        state_nxt   = (mode == oar_pkg::MODE_INDEX) ? S_VALQ : S_PTRQ;
      end
      S_PTRQ: begin
        cmd.asrc    = oar_pkg::ASRC_MEMQ;
        cmd.ea_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        state_nxt   = S_VALQ;
      end
      S_VALQ: begin
        cmd.val_from_mem = 1'b1;
        state_nxt        = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (!slot_r && has_dst_r) begin
            slot_nxt  = 1'b1;
            state_nxt = S_SPEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      spec_r    <= in_spec;
      has_dst_r <= in_has_dest;
    end
  end

endmodule
